@@ hw/rtl/vfa_pkg.sv @@
// Shared types and constants of the 3-vector fixed-point ALU.
package vfa_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  typedef enum logic [3:0] {
    FUNC_ADD   = 4'd0,
    FUNC_SUB   = 4'd1,
    FUNC_SCALE = 4'd2,
    FUNC_DIV   = 4'd3,
    FUNC_EQ    = 4'd4,
    FUNC_NE    = 4'd5,
    FUNC_LENSQ = 4'd6,
    FUNC_LEN   = 4'd7,
    FUNC_NORM  = 4'd8,
    FUNC_DOT   = 4'd9,
    FUNC_MIN_X = 4'd10,
    FUNC_MIN_Y = 4'd11,
    FUNC_MIN_Z = 4'd12,
    FUNC_MAX_X = 4'd13,
    FUNC_MAX_Y = 4'd14,
    FUNC_MAX_Z = 4'd15
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_SAT  = 2'd2
  } err_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic               compare_flag;
    err_e               error_code;
  } out_word_t;

  typedef struct packed {
    in_word_t         word;
    logic [2:0][63:0] prod;
  } mid_word_t;

endpackage

@@ hw/rtl/vfa_fifo.sv @@
// Small register queue used between the front, the back and the result port.
module vfa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/vfa_front.sv @@
// Front end: takes input words, picks multiplicands per operation and registers products.
module vfa_front import vfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_word_t  word_i,
  output logic      full_o,
  output logic      mid_push_o,
  output mid_word_t mid_word_o,
  input  logic      mid_full_i
);

  logic             fr_valid_q, fr_valid_d;
  mid_word_t        fr_q, fr_d;
  logic             accept;
  logic [2:0][31:0] av, mb;

  assign full_o     = fr_valid_q && mid_full_i;
  assign accept     = push_i && !full_o;
  assign mid_push_o = fr_valid_q && !mid_full_i;
  assign mid_word_o = fr_q;

  always_comb begin
    av = {word_i.a_z, word_i.a_y, word_i.a_x};
    unique case (word_i.func) inside
      FUNC_SCALE: mb = {word_i.scalar_in, word_i.scalar_in, word_i.scalar_in};
      FUNC_DOT:   mb = {word_i.b_z, word_i.b_y, word_i.b_x};
      FUNC_LENSQ, FUNC_LEN, FUNC_NORM: mb = av;
      default:    mb = '0;
    endcase
    fr_d.word = word_i;
    for (int i = 0; i < 3; i++) begin
      fr_d.prod[i] = $signed(av[i]) * $signed(mb[i]);
    end
  end

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (mid_push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_q <= fr_d;
    end
  end

endmodule

@@ hw/rtl/vfa_back.sv @@
// Back end: direct operations, pipelined square root and pipelined restoring divide.
module vfa_back import vfa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mid_empty_i,
  input  mid_word_t        mid_word_i,
  output logic             mid_pop_o,
  input  logic [TOL_W-1:0] tol_i,
  input  logic             out_full_i,
  output logic             out_push_o,
  output out_word_t        out_word_o
);

  localparam int unsigned NW       = DW + FRAC_BITS;
  localparam int unsigned SQ_STEPS = DW;
  localparam int unsigned NS       = 1 + SQ_STEPS + NW;
  localparam logic [66:0] HALF     = 67'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    func_e                func;
    logic [2:0]           a_neg;
    logic [2:0][31:0]     a_mag;
    logic                 s_neg;
    logic [31:0]          s_mag;
    logic [65:0]          sum;
    logic [2:0][31:0]     r;
    logic [31:0]          rs;
    logic                 flag;
    err_e                 err;
    logic [63:0]          rad;
    logic [32:0]          srem;
    logic [31:0]          root;
    logic [31:0]          dvsr;
    logic [2:0][NW-1:0]   num;
    logic [2:0][31:0]     drem;
    logic [2:0][NW-1:0]   quo;
  } work_t;

  function automatic logic [32:0] sat32(input logic signed [66:0] v);
    if (v[66:31] == '0 || v[66:31] == '1) begin
      return {1'b0, v[31:0]};
    end else if (v[66]) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b1, 32'h7FFF_FFFF};
  endfunction

  function automatic work_t sqrt_step(input work_t w);
    logic [34:0] rem2;
    logic [34:0] trial;
    rem2  = {w.srem, w.rad[63:62]};
    trial = {1'b0, w.root, 2'b01};
    if (rem2 >= trial) begin
      w.srem = 33'(rem2 - trial);
      w.root = {w.root[30:0], 1'b1};
    end else begin
      w.srem = rem2[32:0];
      w.root = {w.root[30:0], 1'b0};
    end
    w.rad = {w.rad[61:0], 2'b00};
    return w;
  endfunction

  function automatic work_t div_prep(input work_t w);
    w.dvsr = (w.func == FUNC_DIV) ? w.s_mag : w.root;
    for (int i = 0; i < 3; i++) begin
      w.num[i] = {w.a_mag[i], FRAC_BITS'(0)};
    end
    w.drem = '0;
    w.quo  = '0;
    return w;
  endfunction

  function automatic work_t div_step(input work_t w);
    logic [32:0] rem1;
    for (int i = 0; i < 3; i++) begin
      rem1 = {w.drem[i], w.num[i][NW-1]};
      if (rem1 >= {1'b0, w.dvsr}) begin
        w.drem[i] = 32'(rem1 - {1'b0, w.dvsr});
        w.quo[i]  = {w.quo[i][NW-2:0], 1'b1};
      end else begin
        w.drem[i] = rem1[31:0];
        w.quo[i]  = {w.quo[i][NW-2:0], 1'b0};
      end
      w.num[i] = {w.num[i][NW-2:0], 1'b0};
    end
    return w;
  endfunction

  logic          adv;
  work_t         s0_w;
  work_t         stg_d  [NS];
  work_t         pipe_q [NS];
  logic [NS-1:0] vld_q;

  assign adv        = !out_full_i;
  assign mid_pop_o  = adv && !mid_empty_i;
  assign out_push_o = adv && vld_q[NS-1];

  always_comb begin
    in_word_t           w;
    logic [2:0][31:0]   av, bv;
    logic signed [32:0] t33;
    logic [32:0]        dmag;
    logic [32:0]        st;
    logic               eq;
    logic [1:0]         c;
    logic               pick;
    w  = mid_word_i.word;
    av = {w.a_z, w.a_y, w.a_x};
    bv = {w.b_z, w.b_y, w.b_x};
    s0_w       = '0;
    s0_w.func  = w.func;
    s0_w.err   = ERR_OK;
    for (int i = 0; i < 3; i++) begin
      s0_w.a_neg[i] = av[i][31];
      s0_w.a_mag[i] = av[i][31] ? 32'(32'd0 - av[i]) : av[i];
    end
    s0_w.s_neg = w.scalar_in[31];
    s0_w.s_mag = w.scalar_in[31] ? 32'(32'd0 - w.scalar_in) : w.scalar_in;
    s0_w.sum   = 66'($signed(mid_word_i.prod[0])) + 66'($signed(mid_word_i.prod[1]))
               + 66'($signed(mid_word_i.prod[2]));
    s0_w.rad   = s0_w.sum[63:0];
    eq   = 1'b1;
    c    = 2'd0;
    pick = 1'b0;
    t33  = '0;
    dmag = '0;
    st   = '0;
    unique case (w.func) inside
      FUNC_ADD, FUNC_SUB: begin
        for (int i = 0; i < 3; i++) begin
          if (w.func == FUNC_ADD) begin
            t33 = 33'($signed(av[i])) + 33'($signed(bv[i]));
          end else begin
            t33 = 33'($signed(av[i])) - 33'($signed(bv[i]));
          end
          st = sat32(67'(t33));
          s0_w.r[i] = st[31:0];
          if (st[32]) begin
            s0_w.err = ERR_SAT;
          end
        end
      end
      FUNC_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          st = sat32((67'($signed(mid_word_i.prod[i])) + $signed(HALF)) >>> FRAC_BITS);
          s0_w.r[i] = st[31:0];
          if (st[32]) begin
            s0_w.err = ERR_SAT;
          end
        end
      end
      FUNC_EQ, FUNC_NE: begin
        for (int i = 0; i < 3; i++) begin
          t33  = 33'($signed(av[i])) - 33'($signed(bv[i]));
          dmag = t33[32] ? 33'(-t33) : 33'(t33);
          if (!(dmag < 33'(tol_i))) begin
            eq = 1'b0;
          end
        end
        s0_w.flag = (w.func == FUNC_EQ) ? eq : !eq;
      end
      FUNC_MIN_X, FUNC_MIN_Y, FUNC_MIN_Z, FUNC_MAX_X, FUNC_MAX_Y, FUNC_MAX_Z: begin
        case (w.func) inside
          FUNC_MIN_Y, FUNC_MAX_Y: c = 2'd1;
          FUNC_MIN_Z, FUNC_MAX_Z: c = 2'd2;
          default:                c = 2'd0;
        endcase
        if (w.func == FUNC_MIN_X || w.func == FUNC_MIN_Y || w.func == FUNC_MIN_Z) begin
          pick = $signed(av[c]) < $signed(bv[c]);
        end else begin
          pick = $signed(av[c]) > $signed(bv[c]);
        end
        s0_w.r = pick ? av : bv;
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_s0
      assign stg_d[k] = s0_w;
    end else if (k <= SQ_STEPS) begin : g_sqrt
      assign stg_d[k] = sqrt_step(pipe_q[k-1]);
    end else if (k == SQ_STEPS + 1) begin : g_prep
      assign stg_d[k] = div_step(div_prep(pipe_q[k-1]));
    end else begin : g_div
      assign stg_d[k] = div_step(pipe_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], !mid_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        pipe_q[k] <= stg_d[k];
      end
    end
  end

  always_comb begin
    work_t           t;
    logic            neg;
    logic [NW-1:0]   q;
    logic [32:0]     st;
    logic [2:0][31:0] r;
    t   = pipe_q[NS-1];
    r   = t.r;
    neg = 1'b0;
    q   = '0;
    st  = '0;
    out_word_o.res_scalar   = t.rs;
    out_word_o.compare_flag = t.flag;
    out_word_o.error_code   = t.err;
    unique case (t.func) inside
      FUNC_DIV, FUNC_NORM: begin
        if (t.dvsr == '0) begin
          r = '0;
          out_word_o.error_code = ERR_ZERO;
        end else begin
          for (int i = 0; i < 3; i++) begin
            neg = t.a_neg[i] ^ ((t.func == FUNC_DIV) && t.s_neg);
            q   = t.quo[i];
            if (neg) begin
              if (q > NW'(32'h8000_0000)) begin
                r[i] = 32'h8000_0000;
                out_word_o.error_code = ERR_SAT;
              end else begin
                r[i] = 32'd0 - q[31:0];
              end
            end else if (q > NW'(32'h7FFF_FFFF)) begin
              r[i] = 32'h7FFF_FFFF;
              out_word_o.error_code = ERR_SAT;
            end else begin
              r[i] = q[31:0];
            end
          end
        end
      end
      FUNC_LENSQ, FUNC_DOT: begin
        st = sat32((67'($signed(t.sum)) + $signed(HALF)) >>> FRAC_BITS);
        out_word_o.res_scalar = st[31:0];
        if (st[32]) begin
          out_word_o.error_code = ERR_SAT;
        end
      end
      FUNC_LEN: begin
        if (t.root[31]) begin
          out_word_o.res_scalar = 32'h7FFF_FFFF;
          out_word_o.error_code = ERR_SAT;
        end else begin
          out_word_o.res_scalar = t.root;
        end
      end
      default: begin
      end
    endcase
    out_word_o.res_x = r[0];
    out_word_o.res_y = r[1];
    out_word_o.res_z = r[2];
  end

endmodule

@@ hw/rtl/vector3_fixed_point_alu.sv @@
// Top level of the 3-vector fixed-point ALU.
// Values are fixed point (Q16.16 at the default FRAC_BITS); the back end holds
// a 32-step square-root pipeline and a (32 + FRAC_BITS)-step divide pipeline.
// Throughput: one word per cycle while results are popped; every operation goes down
// the same pipeline, so results leave in order.
// Reset: queues and pipeline empty, tolerance register back to 7.
module vector3_fixed_point_alu import vfa_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MID_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  in_word_t         in_word_i,
  output logic             empty,
  input  logic             pop,
  output out_word_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i
);

  logic [TOL_W-1:0] tol_q;
  logic             mid_push, mid_full, mid_empty, mid_pop;
  mid_word_t        mid_in, mid_out;
  logic             res_push, res_full;
  out_word_t        res_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  vfa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .word_i     (in_word_i),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_word_o (mid_in),
    .mid_full_i (mid_full)
  );

  vfa_fifo #(
    .WIDTH ($bits(mid_word_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  vfa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_word_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .tol_i       (tol_q),
    .out_full_i  (res_full),
    .out_push_o  (res_push),
    .out_word_o  (res_word)
  );

  vfa_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

endmodule

@@ hw/rtl/vfa_checker.sv @@
// Port-level checks of the 3-vector fixed-point ALU, bound to the top level.
module vfa_port_props import vfa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_word_o))
    else $error("waiting word changed");

  a_flag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.compare_flag |->
      out_word_o.res_x == 0 && out_word_o.res_y == 0 && out_word_o.res_z == 0 &&
      out_word_o.res_scalar == 0 && out_word_o.error_code == ERR_OK)
    else $error("compare word carries data");

  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.error_code == ERR_ZERO |->
      out_word_o.res_x == 0 && out_word_o.res_y == 0 && out_word_o.res_z == 0 &&
      out_word_o.res_scalar == 0 && !out_word_o.compare_flag)
    else $error("zero-divisor word carries data");

endmodule

bind vector3_fixed_point_alu vfa_port_props u_vfa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_word_o (out_word_o)
);
